// ===== sv/jtag_transaction_shifter_defines.svh =====
// Shared assertion macros.
`ifndef JTAG_TRANSACTION_SHIFTER_DEFINES_SVH
`define JTAG_TRANSACTION_SHIFTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define JTS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jts assertion failed");

// Next-cycle implication, disabled during reset.
`define JTS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jts assertion failed");

`endif

// ===== sv/jts_pkg.sv =====
package jts_pkg;

   localparam int QUEUE_DEPTH    = 8;
   localparam int MAX_SHIFT_BITS = 64;
   localparam int QIDX_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
   localparam int DATA_W         = 64;
   localparam int DATA_IDX_W     = $clog2(DATA_W);
   localparam int KIND_W         = 3;
   localparam int NBITS_W        = 7;
   localparam int HOLD_W         = 16;

   localparam logic [HOLD_W-1:0] TRST_HOLD_RESET = 16'd1000;

   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_TICK    = 1'b1;

   localparam logic [KIND_W-1:0] KIND_SHIFT_DR  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ENTER_IR  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TAP_RESET = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PLAIN     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TRST      = 3'd4;

   typedef struct packed {
      logic                action;
      logic [KIND_W-1:0]   kind;
      logic [NBITS_W-1:0]  bit_count;
      logic [DATA_W-1:0]   tdi_data;
      logic                capture;
      logic                end_in_idle;
      logic                tdo_pin;
   } req_type;

   typedef struct packed {
      logic                tck;
      logic                tms;
      logic                tdi;
      logic                trst_n;
      logic                done_res;
      logic [DATA_W-1:0]   captured_tdo;
      logic                busy_res;
      logic                dropped;
   } rsp_type;

   typedef struct packed {
      logic                rti;
      logic                cap;
      logic [NBITS_W-1:0]  n;
      logic [KIND_W-1:0]   kind;
   } ctrl_type;

   typedef struct packed {
      logic [DATA_W-1:0]   bits;
      ctrl_type            ctrl;
   } q_entry_type;

   // front to back
   typedef struct packed {
      logic tick;
      logic tdo_pin;
      logic nonempty;
   } fe_ctl_type;

   // front status toward the result
   typedef struct packed {
      logic dropped;
      logic nonempty_next;
   } fe_stat_type;

   typedef struct packed {
      logic                tck;
      logic                tms;
      logic                tdi;
      logic                trst_n;
      logic                done;
      logic [DATA_W-1:0]   captured;
      logic                active;
   } eng_res_type;

endpackage

// ===== sv/jts_front.sv =====
`include "jtag_transaction_shifter_defines.svh"

module jts_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  jts_pkg::req_type      item,
   input  logic                  pop,
   output jts_pkg::q_entry_type  head,
   output jts_pkg::fe_ctl_type   ctl,
   output jts_pkg::fe_stat_type  stat
);
   import jts_pkg::*;

   q_entry_type        q_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0]  head_ff, head_in;
   logic [QIDX_W-1:0]  tail_ff, tail_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               full;
   logic               enq;
   logic               push;
   q_entry_type        entry;

   assign full = (count_ff >= QCNT_W'(QUEUE_DEPTH));
   assign enq  = item_valid && (item.action == ACT_ENQUEUE);
   assign push = enq && !full;

   always_comb begin
      entry.bits      = item.tdi_data;
      entry.ctrl.kind = item.kind;
      entry.ctrl.n    = (item.bit_count > NBITS_W'(MAX_SHIFT_BITS)) ?
                        NBITS_W'(MAX_SHIFT_BITS) : item.bit_count;
      entry.ctrl.cap  = item.capture;
      entry.ctrl.rti  = item.end_in_idle;
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in  = (tail_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end else if (pop) begin
         head_in  = (head_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[tail_ff] <= entry;
      end
   end

   assign head = q_ff[head_ff];

   assign ctl.tick     = item_valid && (item.action == ACT_TICK);
   assign ctl.tdo_pin  = item.tdo_pin;
   assign ctl.nonempty = (count_ff != '0);

   assign stat.dropped       = enq && full;
   assign stat.nonempty_next = (count_in != '0);

   `JTS_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= QCNT_W'(QUEUE_DEPTH))
   `JTS_ASSERT_IMP(a_pop_nonempty, clock, reset, pop, (count_ff != '0) && !push)
   `JTS_ASSERT_IMP(a_ptr_match, clock, reset, head_ff == tail_ff,
                   (count_ff == '0) || (count_ff == QCNT_W'(QUEUE_DEPTH)))

endmodule

// ===== sv/jts_engine.sv =====
`include "jtag_transaction_shifter_defines.svh"

module jts_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [jts_pkg::HOLD_W-1:0] csr_wr_data,
   input  jts_pkg::fe_ctl_type       ctl,
   input  jts_pkg::q_entry_type      head,
   output logic                      pop,
   output jts_pkg::eng_res_type      res
);
   import jts_pkg::*;

   typedef struct packed {
      logic tdo;
      logic tdi;
      logic tms;
   } cmd_type;

   function automatic logic [NBITS_W-1:0] pre_len(logic [KIND_W-1:0] k);
      logic [NBITS_W-1:0] r;
      r = '0;
      if (k == KIND_SHIFT_DR) r = NBITS_W'(2);
      if (k == KIND_ENTER_IR) r = NBITS_W'(3);
      return r;
   endfunction

   function automatic logic [NBITS_W-1:0] cmd_count(ctrl_type c);
      logic [NBITS_W-1:0] r;
      case (c.kind)
         KIND_TAP_RESET: r = NBITS_W'(7);
         KIND_TRST:      r = NBITS_W'(2);
         default:        r = pre_len(c.kind) + c.n + (c.rti ? NBITS_W'(3) : NBITS_W'(2));
      endcase
      return r;
   endfunction

   function automatic cmd_type cmd_at(ctrl_type c, logic [DATA_W-1:0] d,
                                      logic [NBITS_W-1:0] pos);
      cmd_type            r;
      logic [NBITS_W-1:0] pre;
      logic [NBITS_W-1:0] p;
      logic [NBITS_W-1:0] q;
      r   = '0;
      pre = pre_len(c.kind);
      p   = pos - pre;
      q   = p - c.n;
      case (c.kind)
         KIND_TAP_RESET: r.tms = (pos < NBITS_W'(5)) || (pos == NBITS_W'(6));
         KIND_TRST:      r.tms = (pos == NBITS_W'(1));
         default: begin
            if (pos < pre) begin
               r.tms = (c.kind == KIND_ENTER_IR) && (pos == '0);
            end else if (p < c.n) begin
               r.tdo = 1'b1;
               r.tdi = d[p[DATA_IDX_W-1:0]];
               r.tms = (p == c.n - 1'b1);
            end else if (q == '0) begin
               r.tms = 1'b1;
            end else if (c.rti) begin
               r.tms = (q == NBITS_W'(2));
            end else begin
               r.tms = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   logic [HOLD_W-1:0]   trst_hold_ff;
   logic                active_ff, active_in;
   logic [NBITS_W-1:0]  pos_ff, pos_in;
   logic                phase_ff, phase_in;
   logic [NBITS_W-1:0]  capidx_ff, capidx_in;
   logic [DATA_W-1:0]   word_ff, word_in;
   logic [HOLD_W-1:0]   hold_ff, hold_in;
   logic                tck_ff, tck_in;
   logic                tms_ff, tms_in;
   logic                tdi_ff, tdi_in;
   logic                trst_n_ff, trst_n_in;
   logic [DATA_W-1:0]   bits_ff, bits_in;
   ctrl_type            ctrl_ff, ctrl_in;
   logic                done;
   logic [DATA_W-1:0]   cap_out;
   logic                go;
   cmd_type             cmd;

   always_comb begin
      active_in = active_ff;
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      capidx_in = capidx_ff;
      word_in   = word_ff;
      hold_in   = hold_ff;
      tck_in    = tck_ff;
      tms_in    = tms_ff;
      tdi_in    = tdi_ff;
      trst_n_in = trst_n_ff;
      bits_in   = bits_ff;
      ctrl_in   = ctrl_ff;
      done      = 1'b0;
      cap_out   = '0;
      pop       = 1'b0;
      go        = 1'b0;
      cmd       = '0;
      if (ctl.tick) begin
         if (active_ff && (hold_ff != '0)) begin
            hold_in = hold_ff - 1'b1;
            if (hold_ff == HOLD_W'(1)) trst_n_in = 1'b1;
         end else begin
            go = 1'b1;
            if (!phase_ff && (!active_ff || (pos_ff >= cmd_count(ctrl_ff)))) begin
               if (active_ff) begin
                  done    = 1'b1;
                  cap_out = ctrl_ff.cap ? word_ff : '0;
                  tdi_in  = 1'b0;
               end
               if (ctl.nonempty) begin
                  pop       = 1'b1;
                  bits_in   = head.bits;
                  ctrl_in   = head.ctrl;
                  active_in = 1'b1;
                  pos_in    = '0;
                  capidx_in = '0;
                  word_in   = '0;
                  if (head.ctrl.kind == KIND_TRST) begin
                     trst_n_in = 1'b0;
                     hold_in   = (trst_hold_ff == '0) ? HOLD_W'(1) : trst_hold_ff;
                     go        = 1'b0;
                  end
               end else begin
                  active_in = 1'b0;
               end
            end
            if (go && active_in) begin
               if (!phase_ff) begin
                  tck_in = 1'b0;
                  if (pos_in < cmd_count(ctrl_in)) begin
                     cmd    = cmd_at(ctrl_in, bits_in, pos_in);
                     pos_in = pos_in + 1'b1;
                  end
                  if (cmd.tdo && ctrl_in.cap && (capidx_in < NBITS_W'(DATA_W))) begin
                     word_in[capidx_in[DATA_IDX_W-1:0]] = ctl.tdo_pin;
                     capidx_in = capidx_in + 1'b1;
                  end
                  tms_in   = cmd.tms;
                  tdi_in   = cmd.tdi;
                  phase_in = 1'b1;
               end else begin
                  tck_in   = 1'b1;
                  phase_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trst_hold_ff <= TRST_HOLD_RESET;
         active_ff    <= 1'b0;
         pos_ff       <= '0;
         phase_ff     <= 1'b0;
         capidx_ff    <= '0;
         word_ff      <= '0;
         hold_ff      <= '0;
         tck_ff       <= 1'b0;
         tms_ff       <= 1'b0;
         tdi_ff       <= 1'b0;
         trst_n_ff    <= 1'b1;
         bits_ff      <= '0;
         ctrl_ff      <= '0;
      end else begin
         if (csr_wr_en) trst_hold_ff <= csr_wr_data;
         active_ff <= active_in;
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         capidx_ff <= capidx_in;
         word_ff   <= word_in;
         hold_ff   <= hold_in;
         tck_ff    <= tck_in;
         tms_ff    <= tms_in;
         tdi_ff    <= tdi_in;
         trst_n_ff <= trst_n_in;
         bits_ff   <= bits_in;
         ctrl_ff   <= ctrl_in;
      end
   end

   assign res.tck      = tck_in;
   assign res.tms      = tms_in;
   assign res.tdi      = tdi_in;
   assign res.trst_n   = trst_n_in;
   assign res.done     = done;
   assign res.captured = cap_out;
   assign res.active   = active_in;

   `JTS_ASSERT_IMP(a_trst_hold, clock, reset, 1'b1, (!trst_n_ff) == (hold_ff != '0))
   `JTS_ASSERT_IMP(a_pos_bound, clock, reset, active_ff, pos_ff <= cmd_count(ctrl_ff))
   `JTS_ASSERT_NEXT(a_tck_rise, clock, reset,
                    ctl.tick && phase_ff && active_ff && (hold_ff == '0),
                    tck_ff && !phase_ff)

endmodule

// ===== sv/jtag_transaction_shifter.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  jts_pkg::req_type (enqueue or tick)
// rsp_      out        rsp_valid/rsp_ready  jts_pkg::rsp_type (pins and status)
// csr_      in         csr_wr_en            trst_hold_ticks, 16 bit
//
// Requests are taken one per cycle while req_ready is high; each gets one registered response.
// The transaction queue and TAP engine both update in the cycle of the transfer.
// A response and a skid entry are held when rsp_ready is low; req_ready drops
// only while the skid entry is occupied.
// Synchronous reset empties the queue and both output stages and idles the engine.
module jtag_transaction_shifter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  jts_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output jts_pkg::rsp_type           rsp_data,
   input  logic                       csr_wr_en,
   input  logic [jts_pkg::HOLD_W-1:0] csr_wr_data
);
   import jts_pkg::*;

   logic         fire;
   logic         pop;
   q_entry_type  head;
   fe_ctl_type   fe_ctl;
   fe_stat_type  fe_stat;
   eng_res_type  eng;
   rsp_type      result;
   logic         rsp_valid_ff;
   rsp_type      rsp_data_ff;
   logic         skid_valid_ff;
   rsp_type      skid_data_ff;

   assign req_ready = !skid_valid_ff;
   assign fire      = req_valid && req_ready;

   jts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .item_valid (fire),
      .item       (req_data),
      .pop        (pop),
      .head       (head),
      .ctl        (fe_ctl),
      .stat       (fe_stat)
   );

   jts_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ctl         (fe_ctl),
      .head        (head),
      .pop         (pop),
      .res         (eng)
   );

   always_comb begin
      result.tck          = eng.tck;
      result.tms          = eng.tms;
      result.tdi          = eng.tdi;
      result.trst_n       = eng.trst_n;
      result.done_res     = eng.done;
      result.captured_tdo = eng.captured;
      result.busy_res     = eng.active || fe_stat.nonempty_next;
      result.dropped      = fe_stat.dropped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= fire;
         end
      end else if (fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_ready) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : result;
      end else if (fire) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
